/* hw/rtl/video_slice_descriptor_gen_assert.svh */
// Assertion macros for the video slice descriptor generator.
// Used by the checker; expects signals named clk and arst_n in the using scope.
`ifndef VIDEO_SLICE_DESCRIPTOR_GEN_ASSERT_SVH
`define VIDEO_SLICE_DESCRIPTOR_GEN_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VSD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define VSD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/vsd_pkg.sv */
// Shared types and constants of the video slice descriptor generator.
// No dependencies; every other RTL file but the assertion header imports this package.
`default_nettype none

package vsd_pkg;

	localparam int ROW_W   = 13;
	localparam int CNT_W   = 8;
	localparam int FN_W    = 32;
	localparam int ST_W    = 64;
	localparam int PITCH_W = 16;
	localparam int ADDR_W  = 32;
	localparam int SIZE_W  = 32;
	localparam int TYPE_W  = 2;
	// The step division works on the row count with four fraction bits.
	localparam int FRAC_W  = 4;
	localparam int DIV_W   = ROW_W + FRAC_W;

	localparam logic [TYPE_W-1:0] FT_NORMAL  = 2'd0;
	localparam logic [TYPE_W-1:0] FT_FIRST   = 2'd1;
	localparam logic [TYPE_W-1:0] FT_PARTIAL = 2'd2;
	localparam logic [TYPE_W-1:0] FT_FINAL   = 2'd3;

	typedef struct packed {
		logic                kind;
		logic [CNT_W-1:0]    slice_count;
		logic [CNT_W-1:0]    slice_index;
		logic [FN_W-1:0]     frame_number;
		logic [ST_W-1:0]     stamp_in;
		logic [ROW_W-1:0]    image_height;
		logic [PITCH_W-1:0]  line_pitch;
		logic [ADDR_W-1:0]   phys_base;
		logic [ADDR_W-1:0]   virt_base;
		logic [ROW_W-1:0]    plane0_rows;
		logic [PITCH_W-1:0]  plane1_pitch;
		logic [ROW_W-1:0]    plane1_rows;
	} notice_t;

	typedef struct packed {
		logic [TYPE_W-1:0] desc_type;
		logic [ADDR_W-1:0] phys_address;
		logic [ADDR_W-1:0] virt_address;
		logic [SIZE_W-1:0] byte_size;
		logic [ST_W-1:0]   stamp_out;
	} desc_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/vsd_if.sv */
// Valid/ready channel interfaces for notices in and descriptors out.
// Depends on vsd_pkg for the field widths.
`default_nettype none

interface vsd_in_if import vsd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [CNT_W-1:0]    slice_count;
	logic [CNT_W-1:0]    slice_index;
	logic [FN_W-1:0]     frame_number;
	logic [ST_W-1:0]     stamp_in;
	logic [ROW_W-1:0]    image_height;
	logic [PITCH_W-1:0]  line_pitch;
	logic [ADDR_W-1:0]   phys_base;
	logic [ADDR_W-1:0]   virt_base;
	logic [ROW_W-1:0]    plane0_rows;
	logic [PITCH_W-1:0]  plane1_pitch;
	logic [ROW_W-1:0]    plane1_rows;

	modport source (
		output valid, kind, slice_count, slice_index, frame_number, stamp_in,
		output image_height, line_pitch, phys_base, virt_base,
		output plane0_rows, plane1_pitch, plane1_rows,
		input  ready
	);
	modport sink (
		input  valid, kind, slice_count, slice_index, frame_number, stamp_in,
		input  image_height, line_pitch, phys_base, virt_base,
		input  plane0_rows, plane1_pitch, plane1_rows,
		output ready
	);
endinterface

interface vsd_out_if import vsd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] desc_type;
	logic [ADDR_W-1:0] phys_address;
	logic [ADDR_W-1:0] virt_address;
	logic [SIZE_W-1:0] byte_size;
	logic [ST_W-1:0]   stamp_out;
	logic              last;

	modport source (
		output valid, desc_type, phys_address, virt_address, byte_size, stamp_out, last,
		input  ready
	);
	modport sink (
		input  valid, desc_type, phys_address, virt_address, byte_size, stamp_out, last,
		output ready
	);
endinterface

`default_nettype wire

/* hw/rtl/vsd_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on vsd_pkg for the request and response structs.
`default_nettype none

module vsd_div import vsd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [STEP_W-1:0] steps_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0] trial;
	logic           fits;

	// The partial remainder stays below the divisor, so one more bit fits in CNT_W+1.
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				steps_q <= STEP_W'(DIV_W);
			end else if (busy_q) begin
				steps_q <= steps_q - STEP_W'(1);
				if (steps_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, dsr_q}) : trial[CNT_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/video_slice_descriptor_gen.sv */
// Top level of the video slice descriptor generator: sequencer, shared multiplier, output register.
// Depends on vsd_pkg, vsd_if and vsd_div.
//
//   channel   modport          role
//   notice    vsd_in_if.sink   frame or slice ready notice, one request per item
//   desc      vsd_out_if.source  transfer descriptors, up to two per notice
//
// A whole-frame notice passes two multiplier steps and two output steps after acceptance
// before its descriptor is offered.
// A slice notice takes up to two passes through the shared divider (17 quotient bits each;
// rows per slice, then the fractional step), besides the flush of an old frame and the
// multiplier steps.
// The notice side is ready only in the idle state; the last descriptor may still wait in the
// output register while the next notice is taken. Reset clears all tracking state at once.
`default_nettype none

module video_slice_descriptor_gen import vsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	vsd_in_if.sink    notice,
	vsd_out_if.source desc
);

	localparam int MUL_A_W = DIV_W;
	localparam int MUL_B_W = ROW_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int PROD_W  = PITCH_W + ROW_W;
	localparam int SUM_W   = MUL_P_W - FRAC_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_WF0    = 4'd1;
	localparam logic [3:0] S_WF1    = 4'd2;
	localparam logic [3:0] S_FLUSH  = 4'd3;
	localparam logic [3:0] S_CHK    = 4'd4;
	localparam logic [3:0] S_DIV1   = 4'd5;
	localparam logic [3:0] S_DIV2   = 4'd6;
	localparam logic [3:0] S_BOUND  = 4'd7;
	localparam logic [3:0] S_DECIDE = 4'd8;
	localparam logic [3:0] S_OFF    = 4'd9;
	localparam logic [3:0] S_SZ     = 4'd10;
	localparam logic [3:0] S_EMIT1  = 4'd11;
	localparam logic [3:0] S_EMIT2  = 4'd12;

	logic [3:0] state_q;

	// Tracking state.
	logic              active_q;
	logic [FN_W-1:0]   held_fn_q;
	logic [ST_W-1:0]   held_stamp_q;
	logic [ROW_W-1:0]  rows_sent_q;
	logic [CNT_W-1:0]  prev_q;

	// Working registers of the item under way.
	notice_t           it_q;
	logic [ST_W-1:0]   st_q;
	logic [ROW_W-1:0]  rows_q;
	logic [TYPE_W-1:0] type_q;
	logic [ST_W-1:0]   dstamp_q;
	logic              use_off_q;
	logic              slice_ph_q;
	logic              start_q;
	logic              nxt_active_q;
	logic [CNT_W-1:0]  nxt_prev_q;
	logic              clr_rs_q;
	logic [ROW_W-2:0]  fh_q;
	logic [DIV_W-1:0]  step_q;
	logic [ROW_W-1:0]  bound_q;
	logic [PROD_W-1:0] off_q;
	logic [PROD_W:0]   wf_q;
	desc_t             fl_q;
	desc_t             sl_q;
	logic              has_fl_q;
	logic              has_sl_q;

	desc_t             out_q;
	logic              out_last_q;
	logic              out_valid_q;

	notice_t           nin;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic               slot_free;
	logic               load_fl;
	logic               load_sl;
	logic               is_last;
	logic               idx_ok;
	logic               new_frame;
	logic [ROW_W-1:0]   rows_fl;
	logic [ROW_W-1:0]   rows_cont;
	logic               take_slice;
	logic [ROW_W-2:0]   fh_div;
	logic [ROW_W-1:0]   h_minus_fh;
	logic [SUM_W-1:0]   bound_sum;
	desc_t              nd;
	desc_t              wd;

	assign nin.kind         = notice.kind;
	assign nin.slice_count  = notice.slice_count;
	assign nin.slice_index  = notice.slice_index;
	assign nin.frame_number = notice.frame_number;
	assign nin.stamp_in     = notice.stamp_in;
	assign nin.image_height = notice.image_height;
	assign nin.line_pitch   = notice.line_pitch;
	assign nin.phys_base    = notice.phys_base;
	assign nin.virt_base    = notice.virt_base;
	assign nin.plane0_rows  = notice.plane0_rows;
	assign nin.plane1_pitch = notice.plane1_pitch;
	assign nin.plane1_rows  = notice.plane1_rows;

	assign notice.ready = (state_q == S_IDLE);

	assign slot_free = !out_valid_q || desc.ready;
	assign load_fl   = (state_q == S_EMIT1) && has_fl_q && slot_free;
	assign load_sl   = (state_q == S_EMIT2) && has_sl_q && slot_free;

	assign is_last   = ({1'b0, it_q.slice_index} + 9'd1) == {1'b0, it_q.slice_count};
	assign idx_ok    = it_q.slice_index < it_q.slice_count;
	assign new_frame = it_q.frame_number != held_fn_q;
	assign rows_fl   = (it_q.image_height > rows_sent_q) ? it_q.image_height - rows_sent_q : '0;
	assign rows_cont = is_last ? rows_fl :
		((bound_q > rows_sent_q) ? bound_q - rows_sent_q : '0);
	assign take_slice = !active_q ||
		((it_q.slice_index > prev_q) && !new_frame && (rows_cont != '0));

	// The quotient of height by slice count never exceeds the height; fh_div keeps its bits ROW_W-1:1.
	assign fh_div     = div_rsp.quotient[ROW_W-1:1];
	assign h_minus_fh = it_q.image_height - {1'b0, fh_div};

	always_comb begin
		div_req.start    = ((state_q == S_CHK) && idx_ok) ||
			((state_q == S_DIV1) && div_rsp.done && !is_last);
		div_req.dividend = (state_q == S_CHK) ? {{FRAC_W{1'b0}}, it_q.image_height}
			: {h_minus_fh, {FRAC_W{1'b0}}};
		div_req.divisor  = (state_q == S_CHK) ? it_q.slice_count
			: it_q.slice_count - CNT_W'(1);
	end

	vsd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// One multiplier serves every product; the sequencer picks the operands.
	always_comb begin
		case (state_q)
			S_WF0: begin
				mul_a = MUL_A_W'(it_q.line_pitch);
				mul_b = it_q.plane0_rows;
			end
			S_WF1: begin
				mul_a = MUL_A_W'(it_q.plane1_pitch);
				mul_b = it_q.plane1_rows;
			end
			S_BOUND: begin
				mul_a = step_q;
				mul_b = MUL_B_W'(it_q.slice_index);
			end
			S_OFF: begin
				mul_a = MUL_A_W'(it_q.line_pitch);
				mul_b = rows_sent_q;
			end
			S_SZ: begin
				mul_a = MUL_A_W'(it_q.line_pitch);
				mul_b = rows_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

	// The boundary never passes the height, so thirteen bits of the sum hold it.
	assign bound_sum = SUM_W'(fh_q) + mul_p[SUM_W+FRAC_W-1:FRAC_W];

	always_comb begin
		nd.desc_type    = type_q;
		nd.phys_address = it_q.phys_base + ADDR_W'(off_q);
		nd.virt_address = it_q.virt_base + ADDR_W'(off_q);
		nd.byte_size    = SIZE_W'(mul_p[PROD_W-1:0]);
		nd.stamp_out    = dstamp_q;

		wd.desc_type    = FT_NORMAL;
		wd.phys_address = it_q.phys_base;
		wd.virt_address = it_q.virt_base;
		wd.byte_size    = SIZE_W'(wf_q) + SIZE_W'(mul_p[PROD_W-1:0]);
		wd.stamp_out    = it_q.stamp_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			active_q     <= 1'b0;
			held_fn_q    <= '0;
			held_stamp_q <= '0;
			rows_sent_q  <= '0;
			prev_q       <= '0;
			has_fl_q     <= 1'b0;
			has_sl_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load_fl || load_sl) begin
				out_valid_q <= 1'b1;
			end else if (desc.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (notice.valid) begin
						has_fl_q <= 1'b0;
						has_sl_q <= 1'b0;
						state_q  <= notice.kind ? S_FLUSH : S_WF0;
					end
				end
				S_WF0: state_q <= S_WF1;
				S_WF1: begin
					has_sl_q <= 1'b1;
					state_q  <= S_EMIT1;
				end
				S_FLUSH: begin
					state_q <= (active_q && new_frame && (rows_fl != '0)) ? S_OFF : S_CHK;
				end
				S_CHK: state_q <= idx_ok ? S_DIV1 : S_EMIT1;
				S_DIV1: begin
					if (div_rsp.done) begin
						state_q <= is_last ? S_DECIDE : S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_rsp.done) begin
						state_q <= S_BOUND;
					end
				end
				S_BOUND: state_q <= S_DECIDE;
				S_DECIDE: state_q <= take_slice ? S_OFF : S_EMIT1;
				S_OFF: state_q <= S_SZ;
				S_SZ: begin
					if (start_q) begin
						held_fn_q    <= it_q.frame_number;
						held_stamp_q <= it_q.stamp_in;
					end
					active_q    <= nxt_active_q;
					prev_q      <= nxt_prev_q;
					rows_sent_q <= (clr_rs_q ? '0 : rows_sent_q) + rows_q;
					if (slice_ph_q) begin
						has_sl_q <= 1'b1;
						state_q  <= S_EMIT1;
					end else begin
						has_fl_q <= 1'b1;
						state_q  <= S_CHK;
					end
				end
				S_EMIT1: begin
					if (!has_fl_q || slot_free) begin
						state_q <= S_EMIT2;
					end
				end
				S_EMIT2: begin
					if (!has_sl_q || slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (notice.valid) begin
					it_q <= nin;
					st_q <= (notice.stamp_in != '0) ? notice.stamp_in : held_stamp_q;
				end
			end
			S_WF0: wf_q <= (PROD_W + 1)'(mul_p[PROD_W-1:0]);
			S_WF1: sl_q <= wd;
			S_FLUSH: begin
				rows_q       <= rows_fl;
				type_q       <= FT_FINAL;
				dstamp_q     <= st_q;
				use_off_q    <= 1'b1;
				slice_ph_q   <= 1'b0;
				start_q      <= 1'b0;
				nxt_active_q <= 1'b0;
				nxt_prev_q   <= '0;
				clr_rs_q     <= 1'b0;
			end
			S_DIV1: begin
				if (div_rsp.done) begin
					fh_q <= fh_div;
				end
			end
			S_DIV2: begin
				if (div_rsp.done) begin
					step_q <= div_rsp.quotient;
				end
			end
			S_BOUND: bound_q <= {bound_sum[ROW_W-1:2], 2'b00};
			S_DECIDE: begin
				slice_ph_q   <= 1'b1;
				nxt_active_q <= !is_last;
				nxt_prev_q   <= is_last ? '0 : it_q.slice_index;
				if (!active_q) begin
					// A new frame starts from the buffer start with the notice's own stamp.
					rows_q    <= is_last ? it_q.image_height : bound_q;
					type_q    <= is_last ? FT_NORMAL : FT_FIRST;
					dstamp_q  <= it_q.stamp_in;
					use_off_q <= 1'b0;
					start_q   <= 1'b1;
					clr_rs_q  <= !is_last;
				end else begin
					rows_q    <= rows_cont;
					type_q    <= is_last ? FT_FINAL : FT_PARTIAL;
					dstamp_q  <= st_q;
					use_off_q <= 1'b1;
					start_q   <= 1'b0;
					clr_rs_q  <= 1'b0;
				end
			end
			S_OFF: off_q <= use_off_q ? mul_p[PROD_W-1:0] : '0;
			S_SZ: begin
				if (slice_ph_q) begin
					sl_q <= nd;
				end else begin
					fl_q <= nd;
				end
			end
			default: begin
			end
		endcase

		if (load_fl) begin
			out_q      <= fl_q;
			out_last_q <= !has_sl_q;
		end else if (load_sl) begin
			out_q      <= sl_q;
			out_last_q <= 1'b1;
		end
	end

	assign desc.valid        = out_valid_q;
	assign desc.desc_type    = out_q.desc_type;
	assign desc.phys_address = out_q.phys_address;
	assign desc.virt_address = out_q.virt_address;
	assign desc.byte_size    = out_q.byte_size;
	assign desc.stamp_out    = out_q.stamp_out;
	assign desc.last         = out_last_q;

endmodule

`default_nettype wire

/* hw/rtl/vsd_checker.sv */
// Port-level checker of the video slice descriptor generator, bound to the top level.
// Depends on vsd_pkg and the assertion macros in video_slice_descriptor_gen_assert.svh.
`default_nettype none

`include "video_slice_descriptor_gen_assert.svh"

module vsd_checker import vsd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [TYPE_W-1:0] out_type,
	input logic [ADDR_W-1:0] out_phys,
	input logic [ADDR_W-1:0] out_virt,
	input logic [SIZE_W-1:0] out_size,
	input logic [ST_W-1:0]   out_stamp,
	input logic              out_last
);

	// A stalled descriptor stays offered.
	`VSD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "descriptor dropped while stalled")

	// A stalled descriptor keeps its contents.
	`VSD_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_type) && $stable(out_phys) && $stable(out_virt) && $stable(out_size) && $stable(out_stamp) && $stable(out_last), "descriptor changed while stalled")

	// Only one request is worked on at a time.
	`VSD_ASSERT_NXT(a_one_request, in_valid && in_ready, !in_ready, "request taken while busy")

	// The only descriptor followed by another one is the flush of an old frame.
	`VSD_ASSERT_IMP(a_nonlast_final, out_valid && !out_last, out_type == FT_FINAL, "non-last descriptor is not a flush")

	// The second descriptor of a request is offered right after the first one is taken.
	`VSD_ASSERT_NXT(a_pair_close, out_valid && out_ready && !out_last, out_valid, "gap inside descriptor pair")

endmodule

bind video_slice_descriptor_gen vsd_checker u_vsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (notice.valid),
	.in_ready  (notice.ready),
	.out_valid (desc.valid),
	.out_ready (desc.ready),
	.out_type  (desc.desc_type),
	.out_phys  (desc.phys_address),
	.out_virt  (desc.virt_address),
	.out_size  (desc.byte_size),
	.out_stamp (desc.stamp_out),
	.out_last  (desc.last)
);

`default_nettype wire
